// ===== sv/ordered_deque_with_removal_assert.svh =====
// Assertion macros used by the queue RTL.
`ifndef ORDERED_DEQUE_WITH_REMOVAL_ASSERT_SVH
`define ORDERED_DEQUE_WITH_REMOVAL_ASSERT_SVH

// Expression holds at every clock edge outside reset.
`define ODQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define ODQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/odq_pkg.sv =====
`default_nettype none
package odq_pkg;

    localparam int CMD_W = 3;
    localparam int ST_W  = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // which cell a removal command targets
    typedef struct packed {
        logic pick_front;
        logic pick_rear;
        logic pick_key;
        logic pick_pos;
    } odq_pick_t;

    // broadcast update for the row of cells
    typedef struct packed {
        logic ins_front;
        logic ins_rear;
        logic remove;
    } odq_upd_t;

endpackage
`default_nettype wire

// ===== sv/odq_cmd_if.sv =====
`default_nettype none
interface odq_cmd_if #(
    parameter int KEY_WIDTH = 16,
    parameter int CNT_W     = 5
);
    import odq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     position;

    modport source (output valid, output cmd, output key, output position, input ready);
    modport sink   (input valid, input cmd, input key, input position, output ready);
endinterface
`default_nettype wire

// ===== sv/odq_res_if.sv =====
`default_nettype none
interface odq_res_if #(
    parameter int KEY_WIDTH = 16,
    parameter int CNT_W     = 5
);
    import odq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [KEY_WIDTH-1:0] removed_key;
    logic [CNT_W-1:0]     count;

    modport source (output valid, output status, output removed_key, output count, input ready);
    modport sink   (input valid, input status, input removed_key, input count, output ready);
endinterface
`default_nettype wire

// ===== sv/odq_cell.sv =====
`default_nettype none
module odq_cell #(
    parameter int KEY_WIDTH = 16,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  wire logic                 clk,
    input  wire odq_pkg::odq_pick_t   pick,
    input  wire odq_pkg::odq_upd_t    upd,
    input  wire logic [CNT_W-1:0]     count,
    input  wire logic [KEY_WIDTH-1:0] search_key,
    input  wire logic [CNT_W-1:0]     position,
    input  wire logic [KEY_WIDTH-1:0] new_key,
    input  wire logic                 rm,
    input  wire logic [KEY_WIDTH-1:0] left_key,
    input  wire logic [KEY_WIDTH-1:0] right_key,
    output logic [KEY_WIDTH-1:0]      key_q,
    output logic                      sel
);
    import odq_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 in_range;

    assign in_range = (IDX < count);

    always_comb
    begin
        sel = in_range & ((pick.pick_front & (IDX == '0))
                        | (pick.pick_rear  & (IDX == count - 1'b1))
                        | (pick.pick_key   & (key_reg == search_key))
                        | (pick.pick_pos   & (position != '0) & (position - 1'b1 == IDX)));
    end

    always_comb
    begin
        key_next = key_reg;
        if (upd.ins_front)
        begin
            key_next = (INDEX == 0) ? new_key : left_key;
        end
        else if (upd.ins_rear && (IDX == count))
        begin
            key_next = new_key;
        end
        else if (upd.remove && rm)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule
`default_nettype wire

// ===== sv/ordered_deque_with_removal.sv =====
// Bounded double-ended queue of keys with removal by key or by position.
// cmd_ch (sink) carries one item per command: cmd, key and a 1-based
// position. res_ch (source) returns one item per command: status, the
// removed key (zero unless something was removed) and the count after it.
// The keys sit in a row of DEPTH cells, front in cell 0; every cell compares
// its key and shifts towards either neighbour.
// In the accept cycle of an item every cell flags whether it is the target;
// in the next cycle the first flagged cell is isolated, the row shifts and
// the result is registered and then held until it is taken. No new item is
// taken while one is executing.
// While a result waits the block is idle and takes a new item at the edge
// at which the result is taken; a stalled receiver therefore holds off the
// sender. Reset empties the queue at once; cell contents need no clearing.
`default_nettype none
module ordered_deque_with_removal #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    odq_cmd_if.sink  cmd_ch,
    odq_res_if.source res_ch
);
    import odq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [DEPTH-1:0] ONE_VEC = DEPTH'(1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [DEPTH-1:0]     hit_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [KEY_WIDTH-1:0] removed_reg, removed_next;

    logic                 accept;
    odq_pick_t            pick;
    odq_upd_t             upd;
    logic [DEPTH-1:0]     first;
    logic [DEPTH-1:0]     rm_mask;
    logic [DEPTH-1:0]     sel;
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic                 is_push, is_remove, full, empty;

    assign cmd_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || res_ch.ready);
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    always_comb
    begin
        pick = '0;
        if (accept)
        begin
            case (cmd_ch.cmd)
                CMD_POP_FRONT: pick.pick_front = 1'b1;
                CMD_POP_REAR:  pick.pick_rear  = 1'b1;
                CMD_DEL_KEY:   pick.pick_key   = 1'b1;
                CMD_DEL_POS:   pick.pick_pos   = 1'b1;
                default:       pick = '0;
            endcase
        end
    end

    // lowest set flag wins, and every cell from there to the rear shifts
    assign first   = hit_reg & (~hit_reg + ONE_VEC);
    assign rm_mask = ~(first - ONE_VEC);

    assign is_push   = (cmd_reg == CMD_PUSH_REAR) || (cmd_reg == CMD_PUSH_FRONT);
    assign is_remove = (cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_REAR)
                    || (cmd_reg == CMD_DEL_KEY)   || (cmd_reg == CMD_DEL_POS);
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    always_comb
    begin
        upd = '0;
        if (state_reg == S_EXEC)
        begin
            upd.ins_front = (cmd_reg == CMD_PUSH_FRONT) && !full;
            upd.ins_rear  = (cmd_reg == CMD_PUSH_REAR) && !full;
            upd.remove    = is_remove && (first != '0);
        end
    end

    always_comb
    begin
        removed_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            removed_next = removed_next | (first[i] ? cell_key[i] : '0);
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        if (is_push && full)
        begin
            status_next = ST_FULL;
        end
        else if (is_remove && empty)
        begin
            status_next = ST_EMPTY;
        end
        else if ((cmd_reg == CMD_DEL_POS) && (hit_reg == '0))
        begin
            status_next = ST_BADPOS;
        end
        else if ((cmd_reg == CMD_DEL_KEY) && (hit_reg == '0))
        begin
            status_next = ST_NOTFOUND;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                if (upd.ins_front || upd.ins_rear)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (upd.remove)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_ch.cmd;
            key_reg <= cmd_ch.key;
            hit_reg <= sel;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            odq_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (g)
            ) u_cell (
                .clk        (clk),
                .pick       (pick),
                .upd        (upd),
                .count      (count_reg),
                .search_key (cmd_ch.key),
                .position   (cmd_ch.position),
                .new_key    (key_reg),
                .rm         (rm_mask[g]),
                .left_key   (cell_key[(g == 0) ? 0 : g - 1]),
                .right_key  (cell_key[(g == DEPTH - 1) ? g : g + 1]),
                .key_q      (cell_key[g]),
                .sel        (sel[g])
            );
        end
    endgenerate

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.status      = status_reg;
    assign res_ch.removed_key = removed_reg;
    assign res_ch.count       = count_reg;

`include "ordered_deque_with_removal_assert.svh"

    `ODQ_ASSERT(a_count_bound, count_reg <= FULL_CNT, "count beyond depth")
    `ODQ_ASSERT(a_single_target,
        (state_reg != S_EXEC) || (cmd_reg == CMD_DEL_KEY) || $onehot0(hit_reg),
        "more than one target cell")
    `ODQ_ASSERT_NEXT(a_accept_exec, accept, (state_reg == S_EXEC) && !out_valid_reg,
        "accept did not start execution")
    `ODQ_ASSERT_NEXT(a_exec_result, state_reg == S_EXEC,
        out_valid_reg && (state_reg == S_IDLE), "execution gave no result")
    `ODQ_ASSERT_NEXT(a_stall_hold, out_valid_reg && !res_ch.ready,
        $stable(count_reg) && out_valid_reg, "queue changed under stalled result")

endmodule
`default_nettype wire

// ===== sim/odq_checker.sv =====
module odq_checker #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 16,
    parameter int CNT_W     = 5
) (
    input  logic clk,
    input  logic rst_n,
    odq_cmd_if   cmd_mon,
    odq_res_if   res_mon,
    output int   errors,
    output int   pending
);
    import odq_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [KEY_WIDTH-1:0] removed_key;
        logic [CNT_W-1:0]     count;
    } odq_result_t;

    // shadow of the queue, front at index 0
    logic [KEY_WIDTH-1:0] held_keys[$];
    odq_result_t          awaited_q[$];
    odq_result_t          want;
    int                   n_results;

    task automatic report(input string what);
        $display("[%0t] result %0d: %s", $realtime, n_results, what);
        errors++;
    endtask

    function automatic odq_result_t apply_command(input logic [CMD_W-1:0] op,
                                                  input logic [KEY_WIDTH-1:0] k,
                                                  input logic [CNT_W-1:0] p);
        odq_result_t r;
        int          hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        case (op)
            CMD_PUSH_REAR, CMD_PUSH_FRONT:
            begin
                if (held_keys.size() >= DEPTH)
                    r.status = ST_FULL;
                else if (op == CMD_PUSH_REAR)
                    held_keys.insert(held_keys.size(), k);
                else
                    held_keys.insert(0, k);
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_DEL_KEY, CMD_DEL_POS:
            begin
                // empty wins over bad position and not found
                if (held_keys.size() == 0)
                    r.status = ST_EMPTY;
                else if (op == CMD_POP_FRONT)
                begin
                    r.removed_key = held_keys[0];
                    held_keys.delete(0);
                end
                else if (op == CMD_POP_REAR)
                begin
                    r.removed_key = held_keys[held_keys.size() - 1];
                    held_keys.delete(held_keys.size() - 1);
                end
                else if (op == CMD_DEL_KEY)
                begin
                    for (int i = 0; i < held_keys.size() && hit < 0; i++)
                        if (held_keys[i] == k)
                            hit = i;
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        r.removed_key = held_keys[hit];
                        held_keys.delete(hit);
                    end
                end
                else if (p == 0 || p > held_keys.size())
                    r.status = ST_BADPOS;
                else
                begin
                    r.removed_key = held_keys[p - 1];
                    held_keys.delete(p - 1);
                end
            end
            default: ;  // spare codes leave the queue alone
        endcase
        r.count = CNT_W'(held_keys.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keys.delete();
            awaited_q.delete();
            errors    = 0;
            pending   = 0;
            n_results = 0;
        end
        else
        begin
            // results leave only after their item was accepted, so check first
            if (res_mon.valid && res_mon.ready)
            begin
                if (awaited_q.size() == 0)
                    report("result item with no command outstanding");
                else
                begin
                    want = awaited_q[0];
                    awaited_q.delete(0);
                    if (res_mon.status !== want.status)
                        report($sformatf("status %0d, want %0d",
                                         res_mon.status, want.status));
                    if (res_mon.removed_key !== want.removed_key)
                        report($sformatf("removed_key %h, want %h",
                                         res_mon.removed_key, want.removed_key));
                    if (res_mon.count !== want.count)
                        report($sformatf("count %0d, want %0d",
                                         res_mon.count, want.count));
                end
                n_results++;
            end
            if (cmd_mon.valid && cmd_mon.ready)
                awaited_q.insert(awaited_q.size(),
                                 apply_command(cmd_mon.cmd, cmd_mon.key,
                                               cmd_mon.position));
            pending = awaited_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import odq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 16;
    localparam int CNT_W     = 5;
    localparam int N_RANDOM  = 750;
    localparam int N_CALM    = 80;
    localparam int LIMIT     = 400000;

    // codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [KEY_WIDTH-1:0] KEY_POOL [8] = '{
        16'h0000, 16'hffff, 16'h8000, 16'h0001,
        16'h1234, 16'h5555, 16'haaaa, 16'h7fff
    };

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   quiet;
    int   tx_idle_pct;
    int   rx_stall_pct;

    odq_cmd_if #(.KEY_WIDTH(KEY_WIDTH), .CNT_W(CNT_W)) cmd_ch ();
    odq_res_if #(.KEY_WIDTH(KEY_WIDTH), .CNT_W(CNT_W)) res_ch ();

    ordered_deque_with_removal #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    odq_checker #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W)
    ) u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_mon (cmd_ch),
        .res_mon (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: ready held high between random stall bursts
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 99) < rx_stall_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [KEY_WIDTH-1:0] k,
                            input logic [CNT_W-1:0] p);
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= op;
        cmd_ch.key      <= k;
        cmd_ch.position <= p;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(0, 1))
            return KEY_POOL[$urandom_range(0, 7)];
        return KEY_WIDTH'($urandom());
    endfunction

    initial
    begin
        int                   sent;
        int                   seg;
        int                   seg_len;
        int                   push_pct;
        int                   r;
        logic [CMD_W-1:0]     op;
        logic [CNT_W-1:0]     p;

        quiet           = 1'b0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = CMD_PUSH_REAR;
        cmd_ch.key      = '0;
        cmd_ch.position = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // removals on an empty queue, then the spare codes and five pushes
        send_cmd(CMD_POP_FRONT, 16'h0000, 5'd1);
        send_cmd(CMD_POP_REAR,  16'h0000, 5'd1);
        send_cmd(CMD_DEL_KEY,   16'hffff, 5'd0);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd0);
        send_cmd(CMD_SPARE_6,   16'hffff, 5'd31);
        send_cmd(CMD_SPARE_7,   16'h0000, 5'd16);
        send_cmd(CMD_PUSH_REAR,  16'h0000, 5'd0);
        send_cmd(CMD_PUSH_FRONT, 16'hffff, 5'd0);
        send_cmd(CMD_PUSH_REAR,  16'h1234, 5'd0);
        send_cmd(CMD_PUSH_REAR,  16'h1234, 5'd0);
        send_cmd(CMD_PUSH_FRONT, 16'h8000, 5'd0);
        // duplicate keys: only the one nearer the front goes
        send_cmd(CMD_DEL_KEY,   16'h1234, 5'd0);
        send_cmd(CMD_DEL_KEY,   16'h5555, 5'd0);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd0);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd5);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd31);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd4);
        send_cmd(CMD_DEL_POS,   16'h0000, 5'd1);
        send_cmd(CMD_POP_REAR,  16'h0000, 5'd0);
        send_cmd(CMD_POP_FRONT, 16'h0000, 5'd0);

        // segments with a push bias so the queue swings between empty and full
        sent = 0;
        seg  = 0;
        while (sent < N_RANDOM)
        begin
            seg_len = $urandom_range(20, 60);
            if (seg == 0)
                push_pct = 90;
            else if (seg == 1)
                push_pct = 10;
            else
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 5;
                default: rx_stall_pct = 20;
            endcase
            for (int j = 0; j < seg_len && sent < N_RANDOM; j++)
            begin
                if (sent >= N_RANDOM - N_CALM)
                    quiet = 1'b1;
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    op = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
                else
                begin
                    r = $urandom_range(0, 20);
                    if (r < 5)
                        op = CMD_POP_FRONT;
                    else if (r < 10)
                        op = CMD_POP_REAR;
                    else if (r < 15)
                        op = CMD_DEL_KEY;
                    else if (r < 20)
                        op = CMD_DEL_POS;
                    else
                        op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
                end
                if ($urandom_range(0, 4) != 0)
                    p = CNT_W'($urandom_range(1, DEPTH + 1));
                else
                    p = CNT_W'($urandom_range(0, 31));
                send_cmd(op, pick_key(), p);
                sent++;
            end
            seg++;
        end

        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
